// File: rtl/fspc_pkg.sv
// ----------------------------------------------------------------------------
// fspc_pkg
// Shared constants, types and decode helpers for the five-stage core.
// ----------------------------------------------------------------------------
package fspc_pkg;

    // Store depth in words; it must be a power of two so that addresses wrap
    // by dropping the upper bits.
    localparam int MEM_WORDS = 65536;
    localparam int AW        = $clog2(MEM_WORDS);

    typedef logic [AW-1:0] addr_t;
    typedef logic [31:0]   word_t;
    typedef logic [9:0]    op_t;
    typedef logic [2:0]    ridx_t;

    localparam op_t OP_ADD  = 10'd0;
    localparam op_t OP_NOR  = 10'd1;
    localparam op_t OP_LW   = 10'd2;
    localparam op_t OP_SW   = 10'd3;
    localparam op_t OP_BEQ  = 10'd4;
    localparam op_t OP_JALR = 10'd5;
    localparam op_t OP_HALT = 10'd6;
    localparam op_t OP_NOOP = 10'd7;

    localparam word_t NOOP_WORD = 32'h01c0_0000;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    function automatic op_t op_of(input word_t w);
        return w[31:22];
    endfunction

    function automatic ridx_t reg_a(input word_t w);
        return w[21:19];
    endfunction

    function automatic ridx_t reg_b(input word_t w);
        return w[18:16];
    endfunction

    function automatic logic writes_reg(input word_t w);
        return (op_of(w) == OP_ADD) || (op_of(w) == OP_NOR) || (op_of(w) == OP_LW);
    endfunction

    function automatic ridx_t dest_reg(input word_t w);
        return (op_of(w) == OP_LW) ? reg_b(w) : w[2:0];
    endfunction

endpackage

// File: rtl/fspc_if.sv
// ----------------------------------------------------------------------------
// fspc_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface fspc_cmd_if;
    import fspc_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic        [15:0] load_addr;
    logic signed [31:0] load_data;

    modport source (output valid, kind, load_addr, load_data, input ready);
    modport sink   (input valid, kind, load_addr, load_data, output ready);
endinterface

interface fspc_res_if;
    import fspc_pkg::*;

    logic               valid;
    logic               ready;
    logic               halted;
    logic               illegal_op;
    logic        [15:0] fetch_pc;
    logic               reg_write;
    logic        [2:0]  reg_index;
    logic signed [31:0] reg_value;
    logic               store_write;
    logic        [15:0] store_addr;
    logic signed [31:0] store_value;
    logic        [31:0] cycle_count;

    modport source (output valid, halted, illegal_op, fetch_pc, reg_write, reg_index,
                    reg_value, store_write, store_addr, store_value, cycle_count,
                    input ready);
    modport sink   (input valid, halted, illegal_op, fetch_pc, reg_write, reg_index,
                    reg_value, store_write, store_addr, store_value, cycle_count,
                    output ready);
endinterface

// File: rtl/fspc_fwd.sv
// ----------------------------------------------------------------------------
// fspc_fwd
// Operand forwarding into EX from the EX/MEM, MEM/WB and end-of-WB latches.
// ----------------------------------------------------------------------------
module fspc_fwd (
    input  fspc_pkg::ridx_t idx,
    input  fspc_pkg::word_t dflt,
    input  fspc_pkg::word_t xm_instr,
    input  fspc_pkg::word_t xm_alu,
    input  fspc_pkg::word_t mw_instr,
    input  fspc_pkg::word_t mw_data,
    input  fspc_pkg::word_t we_instr,
    input  fspc_pkg::word_t we_data,
    output fspc_pkg::word_t val
);
    import fspc_pkg::*;

    // The youngest producer wins; EX/MEM only holds a result for add and nor.
    always_comb
    begin
        priority if ((op_of(xm_instr) == OP_ADD || op_of(xm_instr) == OP_NOR)
                     && xm_instr[2:0] == idx)
        begin
            val = xm_alu;
        end
        else if (writes_reg(mw_instr) && dest_reg(mw_instr) == idx)
        begin
            val = mw_data;
        end
        else if (writes_reg(we_instr) && dest_reg(we_instr) == idx)
        begin
            val = we_data;
        end
        else
        begin
            val = dflt;
        end
    end

endmodule

// File: rtl/five_stage_pipelined_cpu_core.sv
// ----------------------------------------------------------------------------
// five_stage_pipelined_cpu_core
// Five-stage pipelined core for the eight-register teaching ISA.
// ----------------------------------------------------------------------------
// A load transaction writes one word into both the instruction and the data
// store and returns its result through the result register. A tick
// transaction advances the pipeline by one step: it first issues the
// instruction fetch and the data-store read for the MEM stage to the two
// synchronous stores, each with one write port and one read port, then
// evaluates all five stages and writes back unless the machine has stopped.
// The result register parts the two channels, so a new transaction is
// taken when idle once the previous result is consumed or none is pending.
// ----------------------------------------------------------------------------
module five_stage_pipelined_cpu_core (
    input  logic        clk,
    input  logic        rst_n,
    fspc_cmd_if.sink    cmd,
    fspc_res_if.source  res
);
    import fspc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    word_t imem [MEM_WORDS];
    word_t dmem [MEM_WORDS];
    word_t imem_rd, dmem_rd;

    word_t regs_reg [8];

    addr_t pc_reg;
    word_t fd_i_reg;  addr_t fd_p_reg;
    word_t dx_i_reg;  addr_t dx_p_reg;  word_t dx_a_reg, dx_b_reg;  logic [15:0] dx_o_reg;
    word_t xm_i_reg;  addr_t xm_t_reg;  word_t xm_a_reg, xm_b_reg;
    word_t mw_i_reg, mw_d_reg;
    word_t we_i_reg, we_d_reg;
    logic  stop_reg;
    logic [31:0] cnt_reg;

    // Next values of the pipeline for one tick.
    addr_t n_pc;
    word_t n_fd_i;  addr_t n_fd_p;
    word_t n_dx_i;  addr_t n_dx_p;  word_t n_dx_a, n_dx_b;  logic [15:0] n_dx_o;
    word_t n_xm_i;  addr_t n_xm_t;  word_t n_xm_a, n_xm_b;
    word_t n_mw_d;
    logic  stall, taken, sw_do, wb_do, n_stop;
    word_t opa, opb, off_sx, base_pc;
    op_t   fop, xop, mop, nmop;

    // Output register.
    logic        res_valid_reg;
    logic        o_halted_reg, o_illegal_reg, o_rw_reg, o_sw_reg;
    logic [15:0] o_pc_reg, o_sa_reg;
    logic [2:0]  o_ri_reg;
    word_t       o_rv_reg, o_sv_reg;

    logic cmd_fire, tick_fire, exec_go;

    assign cmd.ready = (state_reg == S_IDLE) && (!res_valid_reg || res.ready);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign tick_fire = cmd_fire && (cmd.kind == KIND_TICK);
    assign exec_go   = (state_reg == S_EXEC) && !stop_reg;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  state_next = tick_fire ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Stores: one write port and one registered read port each.
    always_ff @(posedge clk)
    begin
        if (cmd_fire && cmd.kind == KIND_LOAD)
        begin
            imem[AW'(cmd.load_addr)] <= cmd.load_data;
        end
        imem_rd <= imem[pc_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire && cmd.kind == KIND_LOAD)
        begin
            dmem[AW'(cmd.load_addr)] <= cmd.load_data;
        end
        else if (exec_go && sw_do)
        begin
            dmem[AW'(xm_a_reg)] <= xm_b_reg;
        end
        dmem_rd <= dmem[AW'(xm_a_reg)];
    end

    fspc_fwd u_fwd_a (
        .idx      (reg_a(dx_i_reg)),
        .dflt     (dx_a_reg),
        .xm_instr (xm_i_reg),
        .xm_alu   (xm_a_reg),
        .mw_instr (mw_i_reg),
        .mw_data  (mw_d_reg),
        .we_instr (we_i_reg),
        .we_data  (we_d_reg),
        .val      (opa)
    );

    fspc_fwd u_fwd_b (
        .idx      (reg_b(dx_i_reg)),
        .dflt     (dx_b_reg),
        .xm_instr (xm_i_reg),
        .xm_alu   (xm_a_reg),
        .mw_instr (mw_i_reg),
        .mw_data  (mw_d_reg),
        .we_instr (we_i_reg),
        .we_data  (we_d_reg),
        .val      (opb)
    );

    always_comb
    begin
        fop     = op_of(fd_i_reg);
        xop     = op_of(dx_i_reg);
        mop     = op_of(xm_i_reg);
        off_sx  = {{16{dx_o_reg[15]}}, dx_o_reg};
        base_pc = 32'(dx_p_reg);

        // IF
        n_fd_i = imem_rd;
        n_fd_p = pc_reg + 1'b1;
        n_pc   = n_fd_p;

        // ID with load-use interlock
        stall = 1'b0;
        if (xop == OP_LW)
        begin
            if (fop <= OP_BEQ && reg_a(fd_i_reg) == reg_b(dx_i_reg))
            begin
                stall = 1'b1;
            end
            if ((fop == OP_ADD || fop == OP_NOR || fop == OP_SW || fop == OP_BEQ)
                && reg_b(fd_i_reg) == reg_b(dx_i_reg))
            begin
                stall = 1'b1;
            end
        end
        if (stall)
        begin
            n_pc   = pc_reg;
            n_fd_i = fd_i_reg;
            n_fd_p = fd_p_reg;
            n_dx_i = NOOP_WORD;
            n_dx_p = '0;
            n_dx_a = '0;
            n_dx_b = '0;
            n_dx_o = '0;
        end
        else
        begin
            n_dx_i = fd_i_reg;
            n_dx_p = fd_p_reg;
            n_dx_a = regs_reg[reg_a(fd_i_reg)];
            n_dx_b = regs_reg[reg_b(fd_i_reg)];
            n_dx_o = fd_i_reg[15:0];
        end

        // EX
        n_xm_i = dx_i_reg;
        n_xm_t = AW'(base_pc + off_sx);
        n_xm_b = opb;
        unique case (xop)
            OP_ADD:        n_xm_a = opa + opb;
            OP_NOR:        n_xm_a = ~(opa | opb);
            OP_LW, OP_SW:  n_xm_a = 32'(AW'(opa + off_sx));
            OP_BEQ:        n_xm_a = opa - opb;
            default:       n_xm_a = '0;
        endcase

        // MEM
        sw_do  = (mop == OP_SW);
        taken  = (mop == OP_BEQ) && (xm_a_reg == '0);
        unique case (mop)
            OP_ADD, OP_NOR: n_mw_d = xm_a_reg;
            OP_LW:          n_mw_d = dmem_rd;
            default:        n_mw_d = '0;
        endcase
        if (taken)
        begin
            n_fd_i = NOOP_WORD;
            n_fd_p = '0;
            n_dx_i = NOOP_WORD;
            n_dx_p = '0;
            n_dx_a = '0;
            n_dx_b = '0;
            n_dx_o = '0;
            n_xm_i = NOOP_WORD;
            n_xm_t = '0;
            n_xm_a = '0;
            n_xm_b = '0;
            n_pc   = xm_t_reg;
        end

        // WB
        wb_do  = writes_reg(mw_i_reg);
        nmop   = mop;
        n_stop = (nmop == OP_HALT) || (nmop == OP_JALR) || (nmop > OP_NOOP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            fd_i_reg  <= NOOP_WORD;
            fd_p_reg  <= '0;
            dx_i_reg  <= NOOP_WORD;
            dx_p_reg  <= '0;
            dx_a_reg  <= '0;
            dx_b_reg  <= '0;
            dx_o_reg  <= '0;
            xm_i_reg  <= NOOP_WORD;
            xm_t_reg  <= '0;
            xm_a_reg  <= '0;
            xm_b_reg  <= '0;
            mw_i_reg  <= NOOP_WORD;
            mw_d_reg  <= '0;
            we_i_reg  <= NOOP_WORD;
            we_d_reg  <= '0;
            stop_reg  <= 1'b0;
            cnt_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (exec_go)
            begin
                pc_reg   <= n_pc;
                fd_i_reg <= n_fd_i;
                fd_p_reg <= n_fd_p;
                dx_i_reg <= n_dx_i;
                dx_p_reg <= n_dx_p;
                dx_a_reg <= n_dx_a;
                dx_b_reg <= n_dx_b;
                dx_o_reg <= n_dx_o;
                xm_i_reg <= n_xm_i;
                xm_t_reg <= n_xm_t;
                xm_a_reg <= n_xm_a;
                xm_b_reg <= n_xm_b;
                mw_i_reg <= xm_i_reg;
                mw_d_reg <= n_mw_d;
                we_i_reg <= mw_i_reg;
                we_d_reg <= mw_d_reg;
                stop_reg <= n_stop;
                if (cnt_reg != '1)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (wb_do)
                begin
                    regs_reg[dest_reg(mw_i_reg)] <= mw_d_reg;
                end
            end
        end
    end

    // Result register: loads report at once, ticks after the evaluation cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if ((cmd_fire && cmd.kind == KIND_LOAD) || state_reg == S_EXEC)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire && cmd.kind == KIND_LOAD)
        begin
            o_halted_reg  <= stop_reg && op_of(mw_i_reg) == OP_HALT;
            o_illegal_reg <= stop_reg && op_of(mw_i_reg) != OP_HALT;
            o_pc_reg      <= 16'(pc_reg);
            o_rw_reg      <= 1'b0;
            o_ri_reg      <= '0;
            o_rv_reg      <= '0;
            o_sw_reg      <= 1'b0;
            o_sa_reg      <= '0;
            o_sv_reg      <= '0;
        end
        else if (state_reg == S_EXEC)
        begin
            if (exec_go)
            begin
                o_halted_reg  <= n_stop && nmop == OP_HALT;
                o_illegal_reg <= n_stop && nmop != OP_HALT;
                o_pc_reg      <= 16'(n_pc);
                o_rw_reg      <= wb_do;
                o_ri_reg      <= wb_do ? dest_reg(mw_i_reg) : '0;
                o_rv_reg      <= wb_do ? mw_d_reg : '0;
                o_sw_reg      <= sw_do;
                o_sa_reg      <= sw_do ? 16'(AW'(xm_a_reg)) : '0;
                o_sv_reg      <= sw_do ? xm_b_reg : '0;
            end
            else
            begin
                o_halted_reg  <= op_of(mw_i_reg) == OP_HALT;
                o_illegal_reg <= op_of(mw_i_reg) != OP_HALT;
                o_pc_reg      <= 16'(pc_reg);
                o_rw_reg      <= 1'b0;
                o_ri_reg      <= '0;
                o_rv_reg      <= '0;
                o_sw_reg      <= 1'b0;
                o_sa_reg      <= '0;
                o_sv_reg      <= '0;
            end
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.halted      = o_halted_reg;
    assign res.illegal_op  = o_illegal_reg;
    assign res.fetch_pc    = o_pc_reg;
    assign res.reg_write   = o_rw_reg;
    assign res.reg_index   = o_ri_reg;
    assign res.reg_value   = o_rv_reg;
    assign res.store_write = o_sw_reg;
    assign res.store_addr  = o_sa_reg;
    assign res.store_value = o_sv_reg;
    // The counter is only updated in the evaluation cycle, so it is stable
    // whenever a result is presented.
    assign res.cycle_count = cnt_reg;

`ifndef NO_ASSERTIONS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_tick_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire |=> (state_reg == S_EXEC))
        else $error("tick transaction did not enter evaluation");

    a_stop_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |=> stop_reg)
        else $error("stopped machine restarted");

    a_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && stop_reg) |=>
            (res_valid_reg && !o_rw_reg && !o_sw_reg))
        else $error("stopped machine reported a write");
`endif

endmodule
